>>> hdl/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and helper functions shared by the UTF-8 byte stream
// decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

	// Byte masks used when classifying a raw byte.
	localparam logic [7:0] TOP_BIT    = 8'h80;
	localparam logic [7:0] SECOND_BIT = 8'h40;
	localparam logic [7:0] LOW_SIX    = 8'h3F;

	// One input beat.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_data;
	} u8d_item_t;

	// One result beat.
	typedef struct packed {
		logic [31:0] code_point;
		logic        bad_continuation;
		logic        stream_ended;
	} u8d_result_t;

	// A byte after classification by the front end.
	// lead_extra is the number of continuation bytes a lead byte announces,
	// lead_value is the lead byte with its marker bits masked off.
	typedef struct packed {
		logic       end_of_data;
		logic [2:0] lead_extra;
		logic [7:0] lead_value;
		logic [5:0] cont_bits;
		logic       cont_ok;
	} u8d_class_t;

	// Occupancy flags of the classified-byte queue.
	typedef struct packed {
		logic full;
		logic empty;
	} u8d_q_stat_t;

	// Status of the back end seen by the queue and the top level.
	typedef struct packed {
		logic take;
		logic busy;
	} u8d_back_stat_t;

	// Count of leading ones in bits 6..0 of a byte whose bit 7 is set.
	function automatic logic [2:0] lead_ones_after_top(input logic [7:0] b);
		logic [2:0] cnt;
		logic       run;
		cnt = 3'd0;
		run = 1'b1;
		for (int i = 6; i >= 0; i--) begin
			if (run && b[i]) begin
				cnt = cnt + 3'd1;
			end else begin
				run = 1'b0;
			end
		end
		return cnt;
	endfunction

endpackage

>>> hdl/utf8_byte_stream_decoder_core.sv
`timescale 1ns / 1ps
// Results: a beat that completes a character passes through the queue into the output register,
// and the back end takes it from the queue whenever the output register is free.
// Throughput: 1 byte per cycle while the queue is not full; the back end takes one
// queued byte per cycle whenever its output register is empty or being popped.
// Reset: arst_n clears the queue, the decoding state and the output valid flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_core
// Byte-serial UTF-8 decoder: a classifying front end, a queue of classified
// bytes and a decoding back end with a registered result.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8d_pkg::u8d_item_t   item,
	input  logic                 push,
	output logic                 full,
	output u8d_pkg::u8d_result_t result,
	output logic                 empty,
	input  logic                 pop
);

	u8d_pkg::u8d_q_stat_t    q_stat;
	u8d_pkg::u8d_back_stat_t back_stat;
	u8d_pkg::u8d_class_t     q_wdata;
	u8d_pkg::u8d_class_t     q_head;
	logic                    q_wr;

	assign full = q_stat.full;

	// Front end: accept and classify.
	u8d_front u_front (
		.item    (item),
		.push    (push),
		.q_stat  (q_stat),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	// Queue between front and back.
	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_wr),
		.wdata     (q_wdata),
		.back_stat (back_stat),
		.rdata     (q_head),
		.stat      (q_stat)
	);

	// Back end: decode and hold the result.
	u8d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.pop    (pop),
		.empty  (empty),
		.result (result),
		.stat   (back_stat)
	);

`ifndef ASSERT_OFF
	// The back end never takes from an empty queue.
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.take |-> !q_stat.empty)
		else $error("back end took a beat from an empty queue");

	// End of data always returns the decoder to idle.
	a_eod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(back_stat.take && q_head.end_of_data) |=> !back_stat.busy)
		else $error("decoder still busy after end of data");

	// The queue is never full and empty at once.
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue flags inconsistent");
`endif

endmodule

>>> hdl/u8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_front
// Front end: accepts input beats and classifies each byte as a lead or a
// continuation candidate before it enters the queue.
// ----------------------------------------------------------------------------
module u8d_front (
	input  u8d_pkg::u8d_item_t  item,
	input  logic                push,
	input  u8d_pkg::u8d_q_stat_t q_stat,
	output logic                q_wr,
	output u8d_pkg::u8d_class_t q_wdata
);

	logic [2:0] extra;
	logic       is_ascii;

	// A beat is written into the queue whenever it is accepted.
	assign q_wr = push & ~q_stat.full;

	// Classify the byte both ways; the back end picks the view it needs.
	always_comb begin
		is_ascii = (item.byte_value & u8d_pkg::TOP_BIT) == 8'h00;
		extra    = is_ascii ? 3'd0 : u8d_pkg::lead_ones_after_top(item.byte_value);

		q_wdata.end_of_data = item.end_of_data;
		q_wdata.lead_extra  = extra;
		q_wdata.lead_value  = is_ascii ? item.byte_value
		                               : (item.byte_value & (8'h7F >> extra));
		q_wdata.cont_bits   = 6'(item.byte_value & u8d_pkg::LOW_SIX);
		q_wdata.cont_ok     = ((item.byte_value & u8d_pkg::TOP_BIT) != 8'h00) &&
		                      ((item.byte_value & u8d_pkg::SECOND_BIT) == 8'h00);
	end

endmodule

>>> hdl/u8d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_queue
// Small first-in first-out queue of classified bytes between the front and
// back ends.
// ----------------------------------------------------------------------------
module u8d_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  u8d_pkg::u8d_class_t  wdata,
	input  u8d_pkg::u8d_back_stat_t back_stat,
	output u8d_pkg::u8d_class_t  rdata,
	output u8d_pkg::u8d_q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	u8d_pkg::u8d_class_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          rd;

	assign rd         = back_stat.take;
	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign rdata      = mem[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/u8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_back
// Back end: runs the decoding state (remaining count, accumulator, error
// flag) on classified bytes and holds the result in an output register.
// ----------------------------------------------------------------------------
module u8d_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  u8d_pkg::u8d_class_t     head,
	input  u8d_pkg::u8d_q_stat_t    q_stat,
	input  logic                    pop,
	output logic                    empty,
	output u8d_pkg::u8d_result_t    result,
	output u8d_pkg::u8d_back_stat_t stat
);

	logic [2:0]           rem_q;
	logic [31:0]          acc_q;
	logic                 err_q;
	logic                 out_valid_q;
	u8d_pkg::u8d_result_t result_q;

	logic [2:0]           rem_d;
	logic [31:0]          acc_d;
	logic                 err_d;
	logic                 emit;
	u8d_pkg::u8d_result_t res_d;
	logic                 take;

	// Take a byte when one waits and the output register is free or leaving.
	assign take      = ~q_stat.empty & (~out_valid_q | pop);
	assign stat.take = take;
	assign stat.busy = rem_q != 3'd0;
	assign empty     = ~out_valid_q;
	assign result    = result_q;

	// Next decoding state and the result caused by the head byte.
	always_comb begin
		rem_d = rem_q;
		acc_d = acc_q;
		err_d = err_q;
		emit  = 1'b0;
		res_d = '0;
		if (head.end_of_data) begin
			emit                   = 1'b1;
			res_d.bad_continuation = (rem_q != 3'd0) & err_q;
			res_d.stream_ended     = 1'b1;
			rem_d = 3'd0;
			acc_d = '0;
			err_d = 1'b0;
		end else if (rem_q != 3'd0) begin
			err_d = err_q | ~head.cont_ok;
			acc_d = {acc_q[25:0], head.cont_bits};
			rem_d = rem_q - 3'd1;
			if (rem_d == 3'd0) begin
				emit                   = 1'b1;
				res_d.code_point       = acc_d;
				res_d.bad_continuation = err_d;
				acc_d = '0;
				err_d = 1'b0;
			end
		end else if (head.lead_extra == 3'd0) begin
			emit             = 1'b1;
			res_d.code_point = 32'(head.lead_value);
		end else begin
			acc_d = 32'(head.lead_value);
			err_d = 1'b0;
			rem_d = head.lead_extra;
		end
	end

	// Decoding state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			acc_q <= '0;
			err_q <= 1'b0;
		end else if (take) begin
			rem_q <= rem_d;
			acc_q <= acc_d;
			err_q <= err_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			result_q <= res_d;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial UTF-8 decoder. A scoreboard class
// tracks the decoding state of every accepted byte and predicts each code
// point. Every popped beat is compared field by field with the oldest
// prediction. Stimulus is a directed set of corner cases followed by mostly
// well-formed random characters, with randomized idling on both sides and a
// long output stall that backs the decoder up.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES  = 375;

	// Decoding state and pending code points for the bytes sent so far.
	class utf8_scoreboard;
		logic [2:0]  cont_left;
		logic [31:0] acc;
		logic        err_flag;
		u8d_pkg::u8d_result_t code_q[$];
		int          fail_cnt;

		function new();
			cont_left = '0;
			acc       = '0;
			err_flag  = 1'b0;
			fail_cnt  = 0;
		endfunction

		function void clear_char();
			cont_left = '0;
			acc       = '0;
			err_flag  = 1'b0;
		endfunction

		function void add_code(logic [31:0] cp, logic bad, logic ended);
			u8d_pkg::u8d_result_t r;
			r.code_point       = cp;
			r.bad_continuation = bad;
			r.stream_ended     = ended;
			code_q.push_back(r);
		endfunction

		// Advance the decoder state by one accepted byte.
		function void note_byte(u8d_pkg::u8d_item_t it);
			logic [7:0] b;
			int         n;
			b = it.byte_value;
			if (it.end_of_data) begin
				add_code('0, (cont_left != 0) ? err_flag : 1'b0, 1'b1);
				clear_char();
			end else if (cont_left != 0) begin
				// A continuation byte is shifted in even when malformed.
				if ((b & u8d_pkg::TOP_BIT) == 0 || (b & u8d_pkg::SECOND_BIT) != 0) begin
					err_flag = 1'b1;
				end
				acc       = {acc[25:0], b[5:0] & 6'(u8d_pkg::LOW_SIX)};
				cont_left = cont_left - 3'd1;
				if (cont_left == 0) begin
					add_code(acc, err_flag, 1'b0);
					clear_char();
				end
			end else if ((b & u8d_pkg::TOP_BIT) == 0) begin
				add_code({24'd0, b}, 1'b0, 1'b0);
			end else begin
				n = 1;
				while (n < 8 && b[7 - n]) begin
					n++;
				end
				acc       = {24'd0, b & (8'hFF >> n)};
				err_flag  = 1'b0;
				cont_left = 3'(n - 1);
				if (cont_left == 0) begin
					add_code(acc, 1'b0, 1'b0);
					clear_char();
				end
			end
		endfunction

		function void report(string msg);
			if (fail_cnt < 10) begin
				$display("%0t: %s", $realtime, msg);
			end
			fail_cnt++;
		endfunction

		// Compare one popped beat with the oldest predicted code point.
		function void check_result(u8d_pkg::u8d_result_t got);
			u8d_pkg::u8d_result_t want;
			if (code_q.size() == 0) begin
				report($sformatf("unexpected beat: code %h bad %b end %b",
					got.code_point, got.bad_continuation, got.stream_ended));
				return;
			end
			want = code_q.pop_front();
			if (got.code_point !== want.code_point ||
			    got.bad_continuation !== want.bad_continuation ||
			    got.stream_ended !== want.stream_ended) begin
				report($sformatf({"mismatch: expected code %h bad %b end %b, ",
					"got code %h bad %b end %b"},
					want.code_point, want.bad_continuation, want.stream_ended,
					got.code_point, got.bad_continuation, got.stream_ended));
			end
		endfunction

		function void check_leftovers();
			while (code_q.size() != 0) begin
				void'(code_q.pop_front());
				report("expected code point never arrived");
			end
		endfunction

		function int pending();
			return code_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	u8d_pkg::u8d_item_t   item = '0;
	logic                 push = 1'b0;
	logic                 full;
	u8d_pkg::u8d_result_t result;
	logic                 empty;
	logic                 pop = 1'b0;

	utf8_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int bytes_sent  = 0;
	int cycle_count = 0;

	utf8_byte_stream_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	// Clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[utf8_byte_stream_decoder_core] ERROR");
			$finish;
		end
	end

	// Observe both handshakes with the values present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				sb.note_byte(item);
			end
			if (pop && !empty) begin
				sb.check_result(result);
			end
		end
	end

	// Output side: random pop, with an occasional long hold-off.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_cnt != 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (rx_hold_req != 0) begin
				hold_cnt    = rx_hold_req - 1;
				rx_hold_req = 0;
				pop <= 1'b0;
			end else begin
				pop <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offer one byte beat and wait until it is accepted.
	task automatic send_byte(input logic [7:0] b, input logic eod);
		u8d_pkg::u8d_item_t beat;
		beat.byte_value  = b;
		beat.end_of_data = eod;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		item <= beat;
		push <= 1'b1;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	// Hold the input side until every predicted code point has been popped.
	task automatic wait_all_results();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random unit: mostly a well-formed character, sometimes noise or
	// an end-of-data beat, and now and then a broken continuation.
	task automatic send_random_unit();
		int         sel;
		int         n;
		logic [7:0] b;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end else if (sel < 12) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 25) n = 0;
			else if (sel < 30) n = 1;
			else if (sel < 55) n = 2;
			else if (sel < 75) n = 3;
			else if (sel < 88) n = 4;
			else n = $urandom_range(5, 8);
			// Lead byte: n leading ones, then a zero when n is below 8, then random payload.
			b = 8'($urandom_range(0, 255)) & (8'h7F >> n);
			if (n != 0) begin
				b = b | 8'(8'hFF << (8 - n));
			end
			send_byte(b, 1'b0);
			for (int k = 1; k < n; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 2) begin
					send_byte(8'($urandom_range(0, 255)), 1'b1);
					break;
				end else if (sel < 8) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					send_byte(u8d_pkg::TOP_BIT |
						(8'($urandom_range(0, 255)) & u8d_pkg::LOW_SIX), 1'b0);
				end
			end
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			send_random_unit();
		end
	endtask

	// Main sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases with light idling on the input side and heavy idling on the output side.
		tx_idle_pct = 9;
		rx_idle_pct = 67;
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		// Lone continuation bytes used as leads.
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		// Well-formed two and three byte characters.
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		// Continuation with bit 7 clear, then one with bit 6 set.
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		// Lead 0xFF with seven continuations; the accumulator wraps.
		send_byte(8'hFF, 1'b0);
		repeat (7) send_byte(8'hBF, 1'b0);
		// End of data mid-character after a bad continuation.
		send_byte(8'hF0, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'hFF, 1'b1);
		// End of data while idle.
		send_byte(8'hA5, 1'b1);
		wait_all_results();

		// Random phases with different idling on each side.
		run_random(PHASE_BYTES);
		wait_all_results();

		tx_idle_pct = 67;
		rx_idle_pct = 9;
		run_random(PHASE_BYTES);
		wait_all_results();

		// No idling; start with a long output stall so the input backs up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 300;
		run_random(PHASE_BYTES);
		wait_all_results();

		sb.check_leftovers();
		if (sb.fail_cnt == 0) begin
			$display("[utf8_byte_stream_decoder_core] OK");
		end else begin
			$display("[utf8_byte_stream_decoder_core] ERROR");
		end
		$finish;
	end

endmodule
